>>> rtl/turtle_pen_plotter_top_macros.svh
// Assertion macros for the turtle pen plotter
`ifndef TURTLE_PEN_PLOTTER_TOP_MACROS_SVH
`define TURTLE_PEN_PLOTTER_TOP_MACROS_SVH

`ifndef SYNTHESIS

`define TPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("tpp assertion failed");

`define TPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("tpp assertion failed");

`else

`define TPP_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define TPP_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> rtl/tpp_pkg.sv
package tpp_pkg;

	localparam int GRID_SIZE_DEF = 64;
	localparam int POS_W         = 6;
	localparam int DIST_W        = 8;
	localparam int OP_W          = 3;
	localparam int ROW_BITS_W    = 64;

	localparam logic [OP_W-1:0] OP_PEN_DOWN  = 3'd0;
	localparam logic [OP_W-1:0] OP_PEN_UP    = 3'd1;
	localparam logic [OP_W-1:0] OP_TURN_R    = 3'd2;
	localparam logic [OP_W-1:0] OP_TURN_L    = 3'd3;
	localparam logic [OP_W-1:0] OP_MOVE      = 3'd4;
	localparam logic [OP_W-1:0] OP_DUMP      = 3'd5;

	localparam logic [1:0] HD_COL_UP = 2'd0;
	localparam logic [1:0] HD_ROW_UP = 2'd1;
	localparam logic [1:0] HD_COL_DN = 2'd2;
	localparam logic [1:0] HD_ROW_DN = 2'd3;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MOVE,
		ST_TAIL,
		ST_DUMP
	} state_t;

	// clipped move: row and column span to mark, and the new position
	typedef struct packed {
		logic [POS_W-1:0] rlo;
		logic [POS_W-1:0] rhi;
		logic [POS_W-1:0] clo;
		logic [POS_W-1:0] chi;
		logic [POS_W-1:0] new_row;
		logic [POS_W-1:0] new_col;
	} clip_t;

endpackage

>>> rtl/tpp_canvas.sv
module tpp_canvas #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               rd_en,
	input  logic [$clog2(GRID_SIZE)-1:0]       rd_addr,
	output logic [tpp_pkg::ROW_BITS_W-1:0]     rd_data,
	input  logic                               wr_en,
	input  logic [$clog2(GRID_SIZE)-1:0]       wr_addr,
	input  logic [tpp_pkg::ROW_BITS_W-1:0]     wr_data
);

	logic [tpp_pkg::ROW_BITS_W-1:0] mem [GRID_SIZE];
	logic [GRID_SIZE-1:0]           row_valid_q;
	logic [tpp_pkg::ROW_BITS_W-1:0] rd_data_q;
	logic                           rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// a row never written reads as cleared
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q <= '0;
			rd_valid_q  <= 1'b0;
		end else begin
			if (wr_en) begin
				row_valid_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= row_valid_q[rd_addr];
			end
		end
	end

	assign rd_data = rd_valid_q ? rd_data_q : '0;

endmodule

>>> rtl/tpp_clip.sv
module tpp_clip #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input  logic [tpp_pkg::POS_W-1:0]  row,
	input  logic [tpp_pkg::POS_W-1:0]  col,
	input  logic [1:0]                 heading,
	input  logic [tpp_pkg::DIST_W-1:0] distance,
	output tpp_pkg::clip_t             clip
);

	localparam logic [tpp_pkg::POS_W-1:0] LAST_IDX = tpp_pkg::POS_W'(GRID_SIZE - 1);

	logic [tpp_pkg::POS_W-1:0] avail;
	logic [tpp_pkg::POS_W-1:0] steps;

	always_comb begin
		case (heading)
			tpp_pkg::HD_COL_UP: avail = LAST_IDX - col;
			tpp_pkg::HD_ROW_UP: avail = LAST_IDX - row;
			tpp_pkg::HD_COL_DN: avail = col;
			default:            avail = row;
		endcase

		if ({2'b00, avail} > distance) begin
			steps = distance[tpp_pkg::POS_W-1:0];
		end else begin
			steps = avail;
		end

		clip.rlo = row;
		clip.rhi = row;
		clip.clo = col;
		clip.chi = col;
		case (heading)
			tpp_pkg::HD_COL_UP: clip.chi = col + steps;
			tpp_pkg::HD_ROW_UP: clip.rhi = row + steps;
			tpp_pkg::HD_COL_DN: clip.clo = col - steps;
			default:            clip.rlo = row - steps;
		endcase

		case (heading)
			tpp_pkg::HD_ROW_UP: clip.new_row = clip.rhi;
			tpp_pkg::HD_ROW_DN: clip.new_row = clip.rlo;
			default:            clip.new_row = row;
		endcase
		case (heading)
			tpp_pkg::HD_COL_UP: clip.new_col = clip.chi;
			tpp_pkg::HD_COL_DN: clip.new_col = clip.clo;
			default:            clip.new_col = col;
		endcase
	end

endmodule

>>> rtl/turtle_pen_plotter_top.sv
// channel | signals                        | direction | word
// in      | in_valid, in_ready             | into      | operation, distance
// out     | out_valid, out_ready           | out of    | row_index, row_bits, last_row
//
// Pen and turn commands are completed in ST_IDLE. A move with the pen up ends after
// ST_SETUP; with the pen down it does one read-modify-write per row touched (one row
// for a horizontal move, up to GRID_SIZE for a vertical one) on the canvas memory.
// A dump reads one row per cycle while out_ready is high or the output register is empty;
// the single canvas read port sets that pace.
// Reset clears the row valid flags at once; there is no clearing pass.
// out_ready low holds the dump read pipeline; the final row may wait in the output
// register while the next command is taken.
`include "turtle_pen_plotter_top_macros.svh"

module turtle_pen_plotter_top #(
	parameter int GRID_SIZE = tpp_pkg::GRID_SIZE_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic [tpp_pkg::OP_W-1:0]           operation,
	input  logic [tpp_pkg::DIST_W-1:0]         distance,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [tpp_pkg::POS_W-1:0]          row_index,
	output logic [tpp_pkg::ROW_BITS_W-1:0]     row_bits,
	output logic                               last_row
);

	localparam int AW = $clog2(GRID_SIZE);
	localparam logic [tpp_pkg::POS_W-1:0] LAST_IDX = tpp_pkg::POS_W'(GRID_SIZE - 1);

	tpp_pkg::state_t state_q, state_d;

	logic [tpp_pkg::POS_W-1:0]      pen_row_q, pen_col_q;
	logic [1:0]                     heading_q;
	logic                           pen_lowered_q;
	logic [tpp_pkg::DIST_W-1:0]     distance_q;
	logic [tpp_pkg::POS_W-1:0]      row_q, rhi_q, clo_q, chi_q;
	logic                           done_q;
	logic                           wr_pend_s1;
	logic [AW-1:0]                  wr_row_s1;
	logic                           pend_s1;
	logic [tpp_pkg::POS_W-1:0]      row_s1;
	logic                           last_s1;
	logic                           out_valid_q;
	logic [tpp_pkg::POS_W-1:0]      row_index_q;
	logic [tpp_pkg::ROW_BITS_W-1:0] row_bits_q;
	logic                           last_row_q;

	logic                           accept;
	logic                           adv;
	logic                           issue;
	logic                           rd_en;
	logic [tpp_pkg::ROW_BITS_W-1:0] rd_data;
	logic [tpp_pkg::ROW_BITS_W-1:0] col_mask;
	tpp_pkg::clip_t                 clip;

	tpp_clip #(
		.GRID_SIZE (GRID_SIZE)
	) u_clip (
		.row      (pen_row_q),
		.col      (pen_col_q),
		.heading  (heading_q),
		.distance (distance_q),
		.clip     (clip)
	);

	tpp_canvas #(
		.GRID_SIZE (GRID_SIZE)
	) u_canvas (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (rd_en),
		.rd_addr (row_q[AW-1:0]),
		.rd_data (rd_data),
		.wr_en   (wr_pend_s1),
		.wr_addr (wr_row_s1),
		.wr_data (rd_data | col_mask)
	);

	always_comb begin
		for (int j = 0; j < tpp_pkg::ROW_BITS_W; j++) begin
			col_mask[j] = (tpp_pkg::POS_W'(j) >= clo_q) && (tpp_pkg::POS_W'(j) <= chi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tpp_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		adv      = !out_valid_q || out_ready;
		issue    = 1'b0;
		rd_en    = 1'b0;
		case (state_q)
			tpp_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (operation == tpp_pkg::OP_MOVE) begin
						state_d = tpp_pkg::ST_SETUP;
					end else if (operation == tpp_pkg::OP_DUMP) begin
						state_d = tpp_pkg::ST_DUMP;
					end
				end
			end
			tpp_pkg::ST_SETUP: begin
				state_d = pen_lowered_q ? tpp_pkg::ST_MOVE : tpp_pkg::ST_IDLE;
			end
			tpp_pkg::ST_MOVE: begin
				rd_en = 1'b1;
				if (row_q == rhi_q) begin
					state_d = tpp_pkg::ST_TAIL;
				end
			end
			tpp_pkg::ST_TAIL: begin
				state_d = tpp_pkg::ST_IDLE;
			end
			tpp_pkg::ST_DUMP: begin
				issue = adv && !done_q;
				rd_en = issue;
				if (done_q && !pend_s1) begin
					state_d = tpp_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = tpp_pkg::ST_IDLE;
			end
		endcase
	end

	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pen_row_q     <= '0;
			pen_col_q     <= '0;
			heading_q     <= tpp_pkg::HD_COL_UP;
			pen_lowered_q <= 1'b0;
			row_q         <= '0;
			done_q        <= 1'b0;
			wr_pend_s1    <= 1'b0;
			pend_s1       <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			if (accept) begin
				case (operation)
					tpp_pkg::OP_PEN_DOWN: pen_lowered_q <= 1'b1;
					tpp_pkg::OP_PEN_UP:   pen_lowered_q <= 1'b0;
					tpp_pkg::OP_TURN_R:   heading_q <= heading_q + 2'd1;
					tpp_pkg::OP_TURN_L:   heading_q <= heading_q - 2'd1;
					tpp_pkg::OP_DUMP: begin
						row_q  <= '0;
						done_q <= 1'b0;
					end
					default: ;
				endcase
			end
			if (state_q == tpp_pkg::ST_SETUP) begin
				pen_row_q <= clip.new_row;
				pen_col_q <= clip.new_col;
				row_q     <= clip.rlo;
			end
			if (state_q == tpp_pkg::ST_MOVE) begin
				row_q <= row_q + 1'b1;
			end
			if (issue) begin
				row_q <= row_q + 1'b1;
				if (row_q == LAST_IDX) begin
					done_q <= 1'b1;
				end
			end
			wr_pend_s1 <= (state_q == tpp_pkg::ST_MOVE);
			if (adv) begin
				pend_s1     <= issue;
				out_valid_q <= pend_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			distance_q <= distance;
		end
		if (state_q == tpp_pkg::ST_SETUP) begin
			rhi_q <= clip.rhi;
			clo_q <= clip.clo;
			chi_q <= clip.chi;
		end
		wr_row_s1 <= row_q[AW-1:0];
		if (issue) begin
			row_s1  <= row_q;
			last_s1 <= (row_q == LAST_IDX);
		end
		if (adv && pend_s1) begin
			row_index_q <= row_s1;
			row_bits_q  <= rd_data;
			last_row_q  <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign row_index = row_index_q;
	assign row_bits  = row_bits_q;
	assign last_row  = last_row_q;

	`TPP_ASSERT_IMP(a_move_pen_down, clk, arst_n, state_q == tpp_pkg::ST_MOVE, pen_lowered_q)
	`TPP_ASSERT_IMP(a_wr_in_move, clk, arst_n, wr_pend_s1, state_q == tpp_pkg::ST_MOVE || state_q == tpp_pkg::ST_TAIL)
	`TPP_ASSERT_IMP(a_pend_in_dump, clk, arst_n, pend_s1, state_q == tpp_pkg::ST_DUMP)
	`TPP_ASSERT_IMP(a_move_row_range, clk, arst_n, state_q == tpp_pkg::ST_MOVE, row_q <= rhi_q)
	`TPP_ASSERT_NXT(a_last_ends_dump, clk, arst_n, issue && row_q == LAST_IDX, done_q)

endmodule
